// File: hdl/sdc_pkg.sv
package sdc_pkg;

   // Command codes carried by the cmd field of an item.
   localparam logic CMD_TO_SERIAL = 1'b0;
   localparam logic CMD_TO_DATE   = 1'b1;

   // Day number of 1899-12-30 in the March-based count, and that value plus one,
   // which folds in the "day - 1" of the forward formula.
   localparam logic [22:0] EPOCH_DAYS      = 23'd693899;
   localparam logic [23:0] EPOCH_DAYS_INC  = 24'd693900;
   localparam logic [21:0] SERIAL_MAX      = 22'd4194303;

   // Reciprocals for the constant divisions.
   // floor(2^31 / 12053), followed by one correction step.
   localparam logic [17:0] RECIP_12053 = 18'd178170;
   localparam logic [13:0] DIV_12053   = 14'd12053;
   // ceil(2^19 / 100), exact for dividends below 43690.
   localparam logic [12:0] RECIP_100   = 13'd5243;
   // ceil(2^18 / 153), exact for dividends below 2674.
   localparam logic [10:0] RECIP_153   = 11'd1714;

   // An item on its way through the year and day-count stages.
   typedef struct packed {
      logic        cmd;
      logic        y_neg;   // March-based year is -1
      logic [8:0]  mterm;   // days from 1 March to the given day, plus one
      logic [22:0] v;       // serial plus epoch offset
      logic [13:0] y;       // March-based year
   } year_item_type;

   typedef struct packed {
      year_item_type base;
      logic [22:0]   dbm;   // days before 1 March of year y
      logic          leap;  // calendar year y has a 29 February, ending March-based year y-1
   } days_item_type;

   // Days from 1 March to the first of the k-th month of a March-based year.
   function automatic logic [8:0] month_start(input logic [3:0] idx);
      logic [8:0] days;
      case (idx)
         4'd0:    days = 9'd0;
         4'd1:    days = 9'd31;
         4'd2:    days = 9'd61;
         4'd3:    days = 9'd92;
         4'd4:    days = 9'd122;
         4'd5:    days = 9'd153;
         4'd6:    days = 9'd184;
         4'd7:    days = 9'd214;
         4'd8:    days = 9'd245;
         4'd9:    days = 9'd275;
         4'd10:   days = 9'd306;
         4'd11:   days = 9'd337;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

   // (month + 9) mod 12: March becomes 0, February becomes 11.
   function automatic logic [3:0] march_month(input logic [3:0] month);
      logic [4:0] sum;
      logic [3:0] m;
      sum = {1'b0, month} + 5'd9;
      if (sum >= 5'd24) begin
         m = 4'(sum - 5'd24);
      end else if (sum >= 5'd12) begin
         m = 4'(sum - 5'd12);
      end else begin
         m = sum[3:0];
      end
      return m;
   endfunction

endpackage

// File: hdl/sdc_front.sv
module sdc_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic                   in_cmd,
   input  logic [13:0]            in_year,
   input  logic [3:0]             in_month,
   input  logic [4:0]             in_day,
   input  logic [21:0]            in_serial,
   output logic                   out_valid,
   output sdc_pkg::year_item_type out_item
);

   // Stage A: month shift, year adjust, offset serial and the year estimate numerator.
   logic                   a_valid_ff;
   sdc_pkg::year_item_type a_item_ff, a_item_in;
   logic [27:0]            a_num_ff, a_num_in;
   logic [3:0]             a_m0;
   logic                   a_dec;

   always_comb begin
      a_m0            = sdc_pkg::march_month(in_month);
      a_dec           = (a_m0 >= 4'd10);
      a_item_in.cmd   = in_cmd;
      a_item_in.y_neg = (in_year == 14'd0) && a_dec;
      a_item_in.y     = in_year - {13'd0, a_dec};
      a_item_in.mterm = sdc_pkg::month_start(a_m0) + {4'd0, in_day};
      a_item_in.v     = {1'b0, in_serial} + sdc_pkg::EPOCH_DAYS;
      a_num_in        = {a_item_in.v, 5'd0} + {5'd0, a_item_in.v} + 28'd999;
   end

   // Stage B: quotient estimate by reciprocal, at most one too low.
   logic                   b_valid_ff;
   sdc_pkg::year_item_type b_item_ff;
   logic [27:0]            b_num_ff;
   logic [13:0]            b_qe_ff, b_qe_in;
   logic [45:0]            b_prod;

   always_comb begin
      b_prod  = {18'd0, a_num_ff} * {28'd0, sdc_pkg::RECIP_12053};
      b_qe_in = b_prod[44:31];
   end

   // Stage C: remainder check corrects the estimate.
   logic                   c_valid_ff;
   sdc_pkg::year_item_type c_item_ff, c_item_in;
   logic [27:0]            c_back;
   logic [27:0]            c_rem;
   logic                   c_fix;

   always_comb begin
      c_back    = {14'd0, b_qe_ff} * {14'd0, sdc_pkg::DIV_12053};
      c_rem     = b_num_ff - c_back;
      c_fix     = (c_rem >= {14'd0, sdc_pkg::DIV_12053});
      c_item_in = b_item_ff;
      if (b_item_ff.cmd == sdc_pkg::CMD_TO_DATE) begin
         c_item_in.y = b_qe_ff + {13'd0, c_fix};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_item_ff <= a_item_in;
      a_num_ff  <= a_num_in;
      b_item_ff <= a_item_ff;
      b_num_ff  <= a_num_ff;
      b_qe_ff   <= b_qe_in;
      c_item_ff <= c_item_in;
   end

   assign out_valid = c_valid_ff;
   assign out_item  = c_item_ff;

endmodule

// File: hdl/sdc_march_days.sv
module sdc_march_days (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  sdc_pkg::year_item_type in_item,
   output logic                   out_valid,
   output sdc_pkg::days_item_type out_item
);

   // Stage D: the three products of 365y + y/4 - y/100 + y/400.
   logic                   d_valid_ff;
   sdc_pkg::year_item_type d_item_ff;
   logic [7:0]             d_q100_ff, d_q100_in;
   logic [5:0]             d_q400_ff, d_q400_in;
   logic [22:0]            d_y365_ff, d_y365_in;
   logic [26:0]            d_prod100;
   logic [24:0]            d_prod400;

   always_comb begin
      d_prod100 = {13'd0, in_item.y} * {14'd0, sdc_pkg::RECIP_100};
      d_prod400 = {13'd0, in_item.y[13:2]} * {12'd0, sdc_pkg::RECIP_100};
      d_q100_in = d_prod100[26:19];
      d_q400_in = d_prod400[24:19];
      d_y365_in = {9'd0, in_item.y} * 23'd365;
   end

   // Stage E: sum of the terms and the leap test of year y.
   logic                   e_valid_ff;
   sdc_pkg::days_item_type e_item_ff, e_item_in;
   logic [11:0]            e_q4;
   logic                   e_c100;
   logic                   e_c400;

   always_comb begin
      e_q4           = d_item_ff.y[13:2];
      e_c100         = (({6'd0, d_q100_ff} * 14'd100) == d_item_ff.y);
      e_c400         = (({6'd0, d_q400_ff} * 12'd100) == e_q4);
      e_item_in.base = d_item_ff;
      e_item_in.dbm  = d_y365_ff + {11'd0, e_q4} - {15'd0, d_q100_ff} + {17'd0, d_q400_ff};
      e_item_in.leap = (d_item_ff.y[1:0] == 2'd0) && (!e_c100 || e_c400);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else begin
         d_valid_ff <= in_valid;
         e_valid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      d_item_ff <= in_item;
      d_q100_ff <= d_q100_in;
      d_q400_ff <= d_q400_in;
      d_y365_ff <= d_y365_in;
      e_item_ff <= e_item_in;
   end

   assign out_valid = e_valid_ff;
   assign out_item  = e_item_ff;

endmodule

// File: hdl/sdc_back.sv
module sdc_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  sdc_pkg::days_item_type in_item,
   output logic                   out_valid,
   output logic [21:0]            out_serial,
   output logic [26:0]            out_packed_date,
   output logic                   out_before_epoch
);

   // Stage F: serial with flag and saturation, or day of the March-based year.
   logic        f_valid_ff;
   logic        f_cmd_ff;
   logic [21:0] f_serial_ff, f_serial_in;
   logic        f_before_ff, f_before_in;
   logic [8:0]  f_t_ff, f_t_in;
   logic [13:0] f_y_ff, f_y_in;
   logic [23:0] f_sum;
   logic [24:0] f_s;
   logic [23:0] f_t0;
   logic [23:0] f_tadj;

   always_comb begin
      f_sum       = {1'b0, in_item.dbm} + {15'd0, in_item.base.mterm};
      f_s         = {1'b0, f_sum} - {1'b0, sdc_pkg::EPOCH_DAYS_INC};
      f_before_in = in_item.base.y_neg || f_s[24];
      if (f_before_in) begin
         f_serial_in = 22'd0;
      end else if (f_s[23:22] != 2'd0) begin
         f_serial_in = sdc_pkg::SERIAL_MAX;
      end else begin
         f_serial_in = f_s[21:0];
      end

      f_t0   = {1'b0, in_item.base.v} - {1'b0, in_item.dbm};
      f_tadj = f_t0 + 24'd365 + {23'd0, in_item.leap};
      if (f_t0[23]) begin
         f_t_in = f_tadj[8:0];
         f_y_in = in_item.base.y - 14'd1;
      end else begin
         f_t_in = f_t0[8:0];
         f_y_in = in_item.base.y;
      end
   end

   // Stage G: March-based month index by reciprocal of 153.
   logic        g_valid_ff;
   logic        g_cmd_ff;
   logic [21:0] g_serial_ff;
   logic        g_before_ff;
   logic [8:0]  g_t_ff;
   logic [13:0] g_y_ff;
   logic [3:0]  g_mq_ff, g_mq_in;
   logic [10:0] g_x;
   logic [21:0] g_prod;

   always_comb begin
      g_x     = {f_t_ff, 2'd0} + {2'd0, f_t_ff} + 11'd2;
      g_prod  = {11'd0, g_x} * {11'd0, sdc_pkg::RECIP_153};
      g_mq_in = g_prod[21:18];
   end

   // Stage H: calendar month and year, day of month and the packed decimal form.
   logic        h_valid_ff;
   logic [21:0] h_serial_ff, h_serial_in;
   logic [26:0] h_packed_ff, h_packed_in;
   logic        h_before_ff, h_before_in;
   logic [3:0]  h_m;
   logic        h_wrap;
   logic [13:0] h_year;
   logic [3:0]  h_month;
   logic [8:0]  h_day;

   always_comb begin
      h_m     = g_mq_ff + 4'd2;
      h_wrap  = (h_m >= 4'd12);
      h_year  = g_y_ff + {13'd0, h_wrap};
      h_month = h_wrap ? (h_m - 4'd11) : (h_m + 4'd1);
      h_day   = g_t_ff - sdc_pkg::month_start(g_mq_ff) + 9'd1;
      if (g_cmd_ff == sdc_pkg::CMD_TO_DATE) begin
         h_serial_in = 22'd0;
         h_before_in = 1'b0;
         h_packed_in = {13'd0, h_year} * 27'd10000 + {23'd0, h_month} * 27'd100
                       + {18'd0, h_day};
      end else begin
         h_serial_in = g_serial_ff;
         h_before_in = g_before_ff;
         h_packed_in = 27'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
         g_valid_ff <= 1'b0;
         h_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= in_valid;
         g_valid_ff <= f_valid_ff;
         h_valid_ff <= g_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      f_cmd_ff    <= in_item.base.cmd;
      f_serial_ff <= f_serial_in;
      f_before_ff <= f_before_in;
      f_t_ff      <= f_t_in;
      f_y_ff      <= f_y_in;
      g_cmd_ff    <= f_cmd_ff;
      g_serial_ff <= f_serial_ff;
      g_before_ff <= f_before_ff;
      g_t_ff      <= f_t_ff;
      g_y_ff      <= f_y_ff;
      g_mq_ff     <= g_mq_in;
      h_serial_ff <= h_serial_in;
      h_packed_ff <= h_packed_in;
      h_before_ff <= h_before_in;
   end

   assign out_valid        = h_valid_ff;
   assign out_serial       = h_serial_ff;
   assign out_packed_date  = h_packed_ff;
   assign out_before_epoch = h_before_ff;

endmodule

// File: hdl/serial_date_converter.sv
// An item accepted at a rising edge has its result strobed on rsp_valid once it
// has passed through stages A to H in order.
// Throughput: one item per cycle; busy is low whenever reset is low.
// The eight register stages of the pipeline set the latency.
// Reset is synchronous and active high; it empties the pipeline and holds busy high.
module serial_date_converter (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_cmd,
   input  logic [13:0] req_in_year,
   input  logic [3:0]  req_in_month,
   input  logic [4:0]  req_in_day,
   input  logic [21:0] req_in_serial,
   output logic        rsp_valid,
   output logic [21:0] rsp_out_serial,
   output logic [26:0] rsp_packed_date,
   output logic        rsp_before_epoch
);

   // The pipeline never stalls. The receiver must take every result in the cycle it
   // appears, which the block does not enforce. It refuses items only while in reset.
   logic accept;

   assign busy   = reset;
   assign accept = start && !busy;

   // The front end turns a date into its March-based year and day offset, or turns a
   // serial into an estimated March-based year. Both directions then share the
   // days-before-March unit, and the back end finishes whichever conversion the
   // item asked for.
   logic                   front_valid;
   sdc_pkg::year_item_type front_item;
   logic                   days_valid;
   sdc_pkg::days_item_type days_item;

   sdc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_cmd    (req_cmd),
      .in_year   (req_in_year),
      .in_month  (req_in_month),
      .in_day    (req_in_day),
      .in_serial (req_in_serial),
      .out_valid (front_valid),
      .out_item  (front_item)
   );

   sdc_march_days u_days (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_item   (front_item),
      .out_valid (days_valid),
      .out_item  (days_item)
   );

   // Dates before the epoch give serial 0 with the flag set; serials that would not
   // fit the output field saturate at its largest value.
   sdc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (days_valid),
      .in_item          (days_item),
      .out_valid        (rsp_valid),
      .out_serial       (rsp_out_serial),
      .out_packed_date  (rsp_packed_date),
      .out_before_epoch (rsp_before_epoch)
   );

endmodule

// File: hdl/sdc_checker.sv
module sdc_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [21:0] rsp_out_serial,
   input logic [26:0] rsp_packed_date,
   input logic        rsp_before_epoch
);

   // Every accepted item gives its result on rsp_valid.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##8 rsp_valid)
      else $error("accepted item produced no result");

   // No result appears without a matching accepted item.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 8))
      else $error("result without a matching item");

   // A result carries either a serial or a packed date, never both.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_packed_date == 27'd0)
                    || ((rsp_out_serial == 22'd0) && !rsp_before_epoch))
      else $error("serial and packed date both present");

   // A date before the epoch reports serial zero.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_before_epoch) |-> (rsp_out_serial == 22'd0))
      else $error("flagged date carries a non-zero serial");

endmodule

bind serial_date_converter sdc_checker u_sdc_checker (.*);
